// ----- hdl/srh_pkg.sv -----
// Shared types and constants for the sliding-window RMS history core.
// No dependencies; imported by every module of the block.
package srh_pkg;

  localparam int unsigned DEF_WINDOW_DEPTH  = 256;
  localparam int unsigned DEF_HISTORY_DEPTH = 64;
  localparam int unsigned DEF_MAX_CHANNELS  = 4;
  localparam int unsigned NGAIN             = 4;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  localparam logic [2:0] REG_NUM_CH   = 3'd0;
  localparam logic [2:0] REG_WIN_LEN  = 3'd1;
  localparam logic [2:0] REG_HIST_LEN = 3'd2;
  localparam logic [2:0] REG_GAIN0    = 3'd3;
  localparam logic [2:0] REG_GAIN3    = 3'd6;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SMP_UPD,
    ST_TCK_CH,
    ST_TCK_WAIT,
    ST_TCK_EMIT,
    ST_RD_EMIT
  } ctl_state_t;

  typedef enum logic [3:0] {
    R_IDLE,
    R_MUL_LO,
    R_MUL_HI,
    R_ADD,
    R_SUB,
    R_DIV,
    R_SQRT,
    R_SCALE,
    R_SAT,
    R_DONE
  } rms_state_t;

endpackage

// ----- hdl/srh_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on srh_pkg only for the common import convention.
module srh_ram import srh_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/srh_rms_unit.sv -----
// Multi-cycle AC RMS unit: products, restoring divide, bitwise square root, gain.
// Depends on srh_pkg (rms_state_t).
module srh_rms_unit import srh_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [CW-1:0]        n,
  input  logic signed [CW+15:0] sum,
  input  logic [CW+29:0]       sum_sq,
  input  logic [15:0]          gain,
  output logic                 done,
  output logic [31:0]          value
);

  localparam int unsigned SQ_W  = CW + 30;
  localparam int unsigned LO_W  = SQ_W / 2;
  localparam int unsigned HI_W  = SQ_W - LO_W;
  localparam int unsigned AS_W  = CW + 15;
  localparam int unsigned NQ_W  = 2 * CW + 30;
  localparam int unsigned N2_W  = 2 * CW;
  localparam int unsigned DV_W  = NQ_W + 16;
  localparam int unsigned RW    = (DV_W + 1) / 2;
  localparam int unsigned SX_W  = 2 * RW;
  localparam int unsigned CNT_W = $clog2(DV_W + 1);

  rms_state_t st, st_next;

  logic [CW-1:0]         n_q;
  logic [SQ_W-1:0]       sq_q;
  logic [AS_W-1:0]       as_q;
  logic [15:0]           gain_q;
  logic [CW+LO_W-1:0]    p_lo;
  logic [CW+HI_W-1:0]    p_hi;
  logic [NQ_W-1:0]       s2;
  logic [N2_W-1:0]       n2;
  logic [NQ_W-1:0]       nq;
  logic [DV_W-1:0]       dv;
  logic [N2_W-1:0]       rem;
  logic [SX_W-1:0]       xs;
  logic [RW-1:0]         root;
  logic [RW:0]           srem;
  logic [RW+15:0]        prod;
  logic [CNT_W-1:0]      cnt;

  logic [N2_W:0]         div_t;
  logic                  div_ge;
  logic [DV_W-1:0]       dv_step;
  logic [N2_W-1:0]       rem_step;
  logic [RW+2:0]         sq_t;
  logic [RW+2:0]         sq_trial;
  logic                  sq_ge;
  logic [RW+7:0]         scaled;

  always_comb begin
    div_t    = {rem, dv[DV_W-1]};
    div_ge   = div_t >= {1'b0, n2};
    rem_step = div_ge ? N2_W'(div_t - {1'b0, n2}) : div_t[N2_W-1:0];
    dv_step  = {dv[DV_W-2:0], div_ge};
    sq_t     = {srem, xs[SX_W-1 -: 2]};
    sq_trial = (RW+3)'({root, 2'b01});
    sq_ge    = sq_t >= sq_trial;
    scaled   = prod[RW+15:8];
  end

  always_comb begin
    st_next = st;
    unique case (st)
      R_IDLE:   if (start) st_next = R_MUL_LO;
      R_MUL_LO: st_next = R_MUL_HI;
      R_MUL_HI: st_next = R_ADD;
      R_ADD:    st_next = R_SUB;
      R_SUB:    st_next = R_DIV;
      R_DIV:    if (cnt == '0) st_next = R_SQRT;
      R_SQRT:   if (cnt == '0) st_next = R_SCALE;
      R_SCALE:  st_next = R_SAT;
      R_SAT:    st_next = R_DONE;
      R_DONE:   st_next = R_IDLE;
      default:  st_next = R_IDLE;
    endcase
  end

  always_comb begin
    done = (st == R_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= R_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      R_IDLE: begin
        if (start) begin
          n_q    <= n;
          sq_q   <= sum_sq;
          as_q   <= AS_W'(sum[CW+15] ? -sum : sum);
          gain_q <= gain;
        end
      end
      R_MUL_LO: begin
        p_lo <= (CW+LO_W)'(n_q) * (CW+LO_W)'(sq_q[LO_W-1:0]);
        s2   <= NQ_W'(as_q) * NQ_W'(as_q);
        n2   <= N2_W'(n_q) * N2_W'(n_q);
      end
      R_MUL_HI: begin
        p_hi <= (CW+HI_W)'(n_q) * (CW+HI_W)'(sq_q[SQ_W-1:LO_W]);
      end
      R_ADD: begin
        nq <= (NQ_W'(p_hi) << LO_W) + NQ_W'(p_lo);
      end
      R_SUB: begin
        dv  <= {((nq > s2) ? (nq - s2) : NQ_W'(0)), 16'h0000};
        rem <= '0;
        cnt <= CNT_W'(DV_W - 1);
      end
      R_DIV: begin
        dv  <= dv_step;
        rem <= rem_step;
        if (cnt == '0) begin
          xs   <= SX_W'(dv_step);
          root <= '0;
          srem <= '0;
          cnt  <= CNT_W'(RW - 1);
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      R_SQRT: begin
        srem <= sq_ge ? (RW+1)'(sq_t - sq_trial) : (RW+1)'(sq_t);
        root <= {root[RW-2:0], sq_ge};
        xs   <= xs << 2;
        cnt  <= cnt - 1'b1;
      end
      R_SCALE: begin
        prod <= (RW+16)'(root) * (RW+16)'(gain_q);
      end
      R_SAT: begin
        value <= ((scaled >> 32) != '0) ? 32'hFFFF_FFFF : scaled[31:0];
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/sliding_window_rms_history_core.sv -----
// Top level of the sliding-window RMS history core: control, channel state, memories.
// Depends on srh_pkg, srh_ram and srh_rms_unit.
//
// Usage: input words arrive on in_valid/in_ready with cmd, channel, sample and age.
// A sample (cmd 0) updates the channel window and gives no result; it runs the window
// memory read followed by the write-back with the sum update.
// A tick (cmd 1) gives one result per channel in use, in channel order, last on the
// final one; each nonempty channel runs through the RMS unit, 2*CW+30+16 divide
// steps plus half as many root steps and the products, hand-off and scaling.
// Empty channels give a result word with valid_res low and skip the RMS unit.
// A read (cmd 2) gives one result word: the history memory is read on acceptance and
// the word enters the output register from ST_RD_EMIT once that register is free.
// Results leave on out_valid/out_ready through one output register; while the
// receiver stalls, the block holds the pending word and waits. One word is in work
// at a time; in_ready is high when no word is in work.
// Configuration writes use cfg_valid/cfg_ready, always ready; the user must issue them
// only while idle, which the block does not enforce. Reset clears all windows, sums and
// the history ring and loads the register defaults; no clearing pass is needed.
module sliding_window_rms_history_core import srh_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH  = DEF_WINDOW_DEPTH,
  parameter int unsigned HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int unsigned MAX_CHANNELS  = DEF_MAX_CHANNELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [1:0]  channel,
  input  logic signed [15:0] sample,
  input  logic [5:0]  age,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [1:0]  out_channel,
  output logic [31:0] value,
  output logic        valid_res,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned CW     = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned WPW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned HLW    = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned HPW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CHW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned SUM_W  = CW + 16;
  localparam int unsigned SQ_W   = CW + 30;
  localparam int unsigned WMD    = MAX_CHANNELS * WINDOW_DEPTH;
  localparam int unsigned HMD    = MAX_CHANNELS * HISTORY_DEPTH;
  localparam int unsigned WAW    = (WMD > 1) ? $clog2(WMD) : 1;
  localparam int unsigned HAW    = (HMD > 1) ? $clog2(HMD) : 1;
  localparam int unsigned CH_LIM = (MAX_CHANNELS < NGAIN) ? MAX_CHANNELS : NGAIN;

  ctl_state_t state, state_next;

  // configuration
  logic [2:0]  num_ch;
  logic [8:0]  win_len;
  logic [6:0]  hist_len;
  logic [15:0] gain [NGAIN];

  // per-channel window state
  logic [WPW-1:0]          write_pos [MAX_CHANNELS];
  logic [CW-1:0]           fill_count [MAX_CHANNELS];
  logic signed [SUM_W-1:0] run_sum [MAX_CHANNELS];
  logic [SQ_W-1:0]         run_sq [MAX_CHANNELS];
  logic [HPW-1:0]          history_pos;
  logic [HMD-1:0]          hvalid;

  // word in work
  logic [CHW-1:0]     s_ch;
  logic signed [15:0] s_smp;
  logic [WPW-1:0]     s_pos;
  logic [2:0]         tch;
  logic [HPW-1:0]     hp;
  logic               rd_ok;
  logic [1:0]         rd_ch;
  logic               hv_q;

  logic [2:0]     used;
  logic [CW-1:0]  len_eff;
  logic [HLW-1:0] hl_eff;
  logic           in_fire, cfg_fire, out_free;
  logic           ch_ok_in;
  logic [CHW-1:0] ch_in;
  logic [WPW-1:0] pos_in;
  logic [HPW-1:0] hp_g;
  logic [HLW:0]   ridx_a;
  logic [HPW-1:0] ridx;
  logic           rd_req_ok;
  logic [CHW-1:0] tch_idx;
  logic           tch_last;
  logic           tch_empty;

  logic win_rd, smp_upd, tck_start, rd_start, rms_start;
  logic emit_empty, emit_rms, emit_rd, tck_adv;

  logic [WAW-1:0] win_raddr, win_waddr;
  logic [15:0]    win_rdata;
  logic [HAW-1:0] hist_raddr, hist_waddr;
  logic [31:0]    hist_rdata;

  logic                    full;
  logic signed [15:0]      old;
  logic signed [31:0]      smp2, old2;
  logic [CW:0]             pos_inc;
  logic [CW-1:0]           fill_s;

  logic        rms_done;
  logic [31:0] rms_value;

  always_comb begin
    in_fire  = in_valid & in_ready;
    cfg_fire = cfg_valid & cfg_ready;
    out_free = ~out_valid | out_ready;
    used     = (32'(num_ch) > CH_LIM) ? 3'(CH_LIM) : num_ch;
    if (win_len == '0) begin
      len_eff = CW'(1);
    end else if (32'(win_len) > WINDOW_DEPTH) begin
      len_eff = CW'(WINDOW_DEPTH);
    end else begin
      len_eff = CW'(win_len);
    end
    if (hist_len == '0) begin
      hl_eff = HLW'(1);
    end else if (32'(hist_len) > HISTORY_DEPTH) begin
      hl_eff = HLW'(HISTORY_DEPTH);
    end else begin
      hl_eff = HLW'(hist_len);
    end
    ch_ok_in  = {1'b0, channel} < used;
    ch_in     = CHW'(channel);
    pos_in    = (CW'(write_pos[ch_in]) >= len_eff) ? '0 : write_pos[ch_in];
    hp_g      = (32'(history_pos) < 32'(hl_eff)) ? history_pos : '0;
    rd_req_ok = ch_ok_in && (32'(age) < 32'(hl_eff));
    ridx_a    = (HLW+1)'(hp_g) + (HLW+1)'(hl_eff) - (HLW+1)'(1) - (HLW+1)'(age);
    ridx      = (ridx_a >= (HLW+1)'(hl_eff)) ? HPW'(ridx_a - (HLW+1)'(hl_eff))
                                             : HPW'(ridx_a);
    tch_idx   = CHW'(tch);
    tch_last  = (3'(tch + 3'd1) == used);
    tch_empty = (fill_count[tch_idx] == '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_SAMPLE: if (ch_ok_in) state_next = ST_SMP_UPD;
            CMD_TICK:   if (used != '0) state_next = ST_TCK_CH;
            CMD_READ:   state_next = ST_RD_EMIT;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SMP_UPD: state_next = ST_IDLE;
      ST_TCK_CH: begin
        if (!tch_empty) begin
          state_next = ST_TCK_WAIT;
        end else if (out_free) begin
          state_next = tch_last ? ST_IDLE : ST_TCK_CH;
        end
      end
      ST_TCK_WAIT: if (rms_done) state_next = ST_TCK_EMIT;
      ST_TCK_EMIT: if (out_free) state_next = tch_last ? ST_IDLE : ST_TCK_CH;
      ST_RD_EMIT:  if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE);
    cfg_ready  = 1'b1;
    win_rd     = (state == ST_IDLE) && in_fire && (cmd == CMD_SAMPLE) && ch_ok_in;
    tck_start  = (state == ST_IDLE) && in_fire && (cmd == CMD_TICK);
    rd_start   = (state == ST_IDLE) && in_fire && (cmd == CMD_READ);
    smp_upd    = (state == ST_SMP_UPD);
    rms_start  = (state == ST_TCK_CH) && !tch_empty;
    emit_empty = (state == ST_TCK_CH) && tch_empty && out_free;
    emit_rms   = (state == ST_TCK_EMIT) && out_free;
    emit_rd    = (state == ST_RD_EMIT) && out_free;
    tck_adv    = ((emit_empty || emit_rms) && tch_last) || (tck_start && (used == '0));
  end

  // sample update path
  always_comb begin
    full    = (fill_count[s_ch] >= len_eff);
    old     = full ? signed'(win_rdata) : 16'sd0;
    smp2    = s_smp * s_smp;
    old2    = old * old;
    pos_inc = (CW+1)'(s_pos) + (CW+1)'(1);
    fill_s  = full ? len_eff : CW'(fill_count[s_ch] + 1'b1);
  end

  always_comb begin
    win_raddr  = WAW'(ch_in) * WAW'(WINDOW_DEPTH) + WAW'(pos_in);
    win_waddr  = WAW'(s_ch) * WAW'(WINDOW_DEPTH) + WAW'(s_pos);
    hist_raddr = HAW'(ch_in) * HAW'(HISTORY_DEPTH) + HAW'(ridx);
    hist_waddr = HAW'(tch_idx) * HAW'(HISTORY_DEPTH) + HAW'(hp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      num_ch      <= 3'd3;
      win_len     <= 9'd256;
      hist_len    <= 7'd64;
      history_pos <= '0;
      hvalid      <= '0;
      for (int i = 0; i < NGAIN; i++) begin
        gain[i] <= 16'd256;
      end
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        write_pos[i]  <= '0;
        fill_count[i] <= '0;
        run_sum[i]    <= '0;
        run_sq[i]     <= '0;
      end
    end else begin
      state <= state_next;
      if (emit_empty || emit_rms || emit_rd) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (smp_upd) begin
        run_sum[s_ch]    <= run_sum[s_ch] + SUM_W'(s_smp) - SUM_W'(old);
        run_sq[s_ch]     <= run_sq[s_ch] + SQ_W'($unsigned(smp2)) - SQ_W'($unsigned(old2));
        fill_count[s_ch] <= fill_s;
        write_pos[s_ch]  <= (pos_inc >= (CW+1)'(len_eff)) ? '0 : WPW'(pos_inc);
      end
      if (emit_rms) begin
        hvalid[hist_waddr] <= 1'b1;
      end
      if (tck_adv) begin
        history_pos <= (32'(hp_g) + 1 >= 32'(hl_eff)) ? '0 : HPW'(hp_g + 1'b1);
      end
      if (cfg_fire) begin
        unique case (cfg_index) inside
          REG_NUM_CH: num_ch <= cfg_data[2:0];
          REG_WIN_LEN: begin
            win_len <= cfg_data[8:0];
            for (int i = 0; i < MAX_CHANNELS; i++) begin
              write_pos[i]  <= '0;
              fill_count[i] <= '0;
              run_sum[i]    <= '0;
              run_sq[i]     <= '0;
            end
          end
          REG_HIST_LEN: begin
            hist_len    <= cfg_data[6:0];
            history_pos <= '0;
            hvalid      <= '0;
          end
          [REG_GAIN0:REG_GAIN3]: gain[2'(cfg_index - REG_GAIN0)] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (win_rd) begin
      s_ch  <= ch_in;
      s_smp <= sample;
      s_pos <= pos_in;
    end
    if (tck_start) begin
      tch <= '0;
      hp  <= hp_g;
    end else if ((emit_empty || emit_rms) && !tch_last) begin
      tch <= tch + 3'd1;
    end
    if (rd_start) begin
      rd_ok <= rd_req_ok;
      rd_ch <= channel;
      hv_q  <= rd_req_ok ? hvalid[hist_raddr] : 1'b0;
    end
    if (emit_empty || emit_rms) begin
      kind        <= KIND_TICK;
      out_channel <= 2'(tch);
      value       <= emit_rms ? rms_value : '0;
      valid_res   <= emit_rms;
      last        <= tch_last;
    end else if (emit_rd) begin
      kind        <= KIND_READ;
      out_channel <= rd_ch;
      value       <= (rd_ok && hv_q) ? hist_rdata : '0;
      valid_res   <= rd_ok;
      last        <= 1'b1;
    end
  end

  srh_ram #(.DEPTH(WMD), .WIDTH(16)) u_win_ram (
    .clk   (clk),
    .we    (smp_upd),
    .waddr (win_waddr),
    .wdata (s_smp),
    .re    (win_rd),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  srh_ram #(.DEPTH(HMD), .WIDTH(32)) u_hist_ram (
    .clk   (clk),
    .we    (emit_rms),
    .waddr (hist_waddr),
    .wdata (rms_value),
    .re    (rd_start && rd_req_ok),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  srh_rms_unit #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_rms (
    .clk    (clk),
    .rst    (rst),
    .start  (rms_start),
    .n      (fill_count[tch_idx]),
    .sum    (run_sum[tch_idx]),
    .sum_sq (run_sq[tch_idx]),
    .gain   (gain[2'(tch)]),
    .done   (rms_done),
    .value  (rms_value)
  );

  a_hist_pos_range: assert property (@(posedge clk) disable iff (rst)
    32'(history_pos) < 32'(hl_eff))
    else $error("history position beyond ring length");

  a_rms_done_waiting: assert property (@(posedge clk) disable iff (rst)
    rms_done |-> state == ST_TCK_WAIT)
    else $error("rms result with no tick waiting");

  a_tick_ch_used: assert property (@(posedge clk) disable iff (rst)
    (emit_empty || emit_rms) |-> tch < used)
    else $error("tick word for channel not in use");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    smp_upd |=> fill_count[$past(s_ch)] <= len_eff)
    else $error("window fill exceeds length");

endmodule

// ----- test/sliding_window_rms_history_checker.sv -----
`timescale 1ns / 100ps
// Checker for the sliding-window RMS history core: watches the input, config and
// result channels, keeps its own window and history model, compares every result word.
// Depends on srh_pkg.
module sliding_window_rms_history_checker import srh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [1:0]  channel,
  input  logic signed [15:0] sample,
  input  logic [5:0]  age,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        kind,
  input  logic [1:0]  out_channel,
  input  logic [31:0] value,
  input  logic        valid_res,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          ticks_seen,
  output int          reads_seen
);

  typedef struct {
    logic        kind;
    logic [1:0]  chan;
    logic [31:0] val;
    logic        ok;
    logic        lst;
  } rms_word_t;

  logic [2:0]  chans_reg;
  logic [8:0]  win_reg;
  logic [6:0]  hist_reg;
  logic [15:0] gain[4];

  logic signed [15:0] win_mem[4][256];
  int unsigned        wr_pos[4];
  int unsigned        fill[4];
  longint             sum[4];
  longint unsigned    sum_sq[4];
  logic [31:0]        hist_mem[4][64];
  int unsigned        hist_pos;

  rms_word_t expected_words[$];

  assign pending = expected_words.size();

  function automatic int unsigned chans_in_use();
    return (chans_reg > 4) ? 4 : chans_reg;
  endfunction

  function automatic int unsigned win_len();
    if (win_reg == 0) return 1;
    return (win_reg > 256) ? 256 : win_reg;
  endfunction

  function automatic int unsigned hist_len();
    if (hist_reg == 0) return 1;
    return (hist_reg > 64) ? 64 : hist_reg;
  endfunction

  task automatic clear_windows();
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 256; i++) win_mem[c][i] = '0;
      wr_pos[c] = 0;
      fill[c]   = 0;
      sum[c]    = 0;
      sum_sq[c] = 0;
    end
  endtask

  task automatic clear_history();
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 64; i++) hist_mem[c][i] = '0;
    hist_pos = 0;
  endtask

  // AC RMS in Q.8 scaled by the channel gain
  function automatic logic [31:0] scaled_rms(int c);
    longint unsigned n, n2, nq, s2, d, q, r, var_q16, root, bitv, x, scaled;
    longint s;
    n = fill[c];
    n2 = n * n;
    nq = n * sum_sq[c];
    s = (sum[c] < 0) ? -sum[c] : sum[c];
    s2 = longint'(s) * longint'(s);
    d = (nq > s2) ? nq - s2 : 0;
    q = d / n2;
    r = d % n2;
    var_q16 = (q << 16) + ((r << 16) / n2);
    root = 0;
    x = var_q16;
    bitv = 64'h1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    scaled = (root * longint'(gain[c])) >> 8;
    return (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
  endfunction

  task automatic predict(logic [1:0] op, int unsigned ch, logic signed [15:0] smp,
                         int unsigned ag);
    int unsigned used, len, pos, hl, hp, idx;
    logic signed [15:0] old;
    rms_word_t w;
    used = chans_in_use();
    case (op)
      CMD_SAMPLE: begin
        if (ch < used) begin
          len = win_len();
          pos = (wr_pos[ch] >= len) ? 0 : wr_pos[ch];
          if (fill[ch] >= len) begin
            old = win_mem[ch][pos];
            sum[ch] = sum[ch] - longint'(old);
            sum_sq[ch] = sum_sq[ch] - longint'(old) * longint'(old);
            fill[ch] = len;
          end else begin
            fill[ch]++;
          end
          win_mem[ch][pos] = smp;
          sum[ch] = sum[ch] + longint'(smp);
          sum_sq[ch] = sum_sq[ch] + longint'(smp) * longint'(smp);
          wr_pos[ch] = (pos + 1 >= len) ? 0 : pos + 1;
        end
      end
      CMD_TICK: begin
        hl = hist_len();
        hp = (hist_pos < hl) ? hist_pos : 0;
        for (int c = 0; c < used; c++) begin
          w.kind = KIND_TICK;
          w.chan = 2'(c);
          w.ok   = (fill[c] > 0);
          w.val  = '0;
          w.lst  = (c + 1 == used);
          if (w.ok) begin
            w.val = scaled_rms(c);
            hist_mem[c][hp] = w.val;
          end
          expected_words.push_back(w);
        end
        hist_pos = (hp + 1 >= hl) ? 0 : hp + 1;
      end
      CMD_READ: begin
        hl = hist_len();
        hp = (hist_pos < hl) ? hist_pos : 0;
        w.kind = KIND_READ;
        w.chan = 2'(ch);
        w.lst  = 1'b1;
        if (ch >= used || ag >= hl) begin
          w.val = '0;
          w.ok  = 1'b0;
        end else begin
          idx = (hp + 2 * hl - 1 - ag) % hl;
          w.val = hist_mem[ch][idx];
          w.ok  = 1'b1;
        end
        expected_words.push_back(w);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    rms_word_t w;
    if (rst) begin
      chans_reg = 3'd3;
      win_reg   = 9'd256;
      hist_reg  = 7'd64;
      for (int i = 0; i < 4; i++) gain[i] = 16'd256;
      clear_windows();
      clear_history();
      expected_words.delete();
      mismatches <= 0;
      ticks_seen <= 0;
      reads_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_CH:   chans_reg = cfg_data[2:0];
          REG_WIN_LEN: begin
            win_reg = cfg_data[8:0];
            clear_windows();
          end
          REG_HIST_LEN: begin
            hist_reg = cfg_data[6:0];
            clear_history();
          end
          default:
            if (cfg_index >= REG_GAIN0 && cfg_index <= REG_GAIN3)
              gain[cfg_index - REG_GAIN0] = cfg_data;
        endcase
      end
      if (out_valid && out_ready) begin
        if (kind == KIND_TICK) ticks_seen <= ticks_seen + 1;
        else reads_seen <= reads_seen + 1;
        if (expected_words.size() == 0) begin
          $error("unexpected result word: kind %0d channel %0d value %0h",
                 kind, out_channel, value);
          mismatches <= mismatches + 1;
        end else begin
          w = expected_words.pop_front();
          if (kind !== w.kind || out_channel !== w.chan || value !== w.val ||
              valid_res !== w.ok || last !== w.lst) begin
            mismatches <= mismatches + 1;
            if (kind !== w.kind) $error("kind: expected %0d, got %0d", w.kind, kind);
            if (out_channel !== w.chan)
              $error("out_channel: expected %0d, got %0d", w.chan, out_channel);
            if (value !== w.val) $error("value: expected %0h, got %0h", w.val, value);
            if (valid_res !== w.ok)
              $error("valid_res: expected %0d, got %0d", w.ok, valid_res);
            if (last !== w.lst) $error("last: expected %0d, got %0d", w.lst, last);
          end
        end
      end
      if (in_valid && in_ready) predict(cmd, channel, sample, age);
    end
  end

endmodule

// ----- test/sliding_window_rms_history_core_test.sv -----
`timescale 1ns / 100ps
// Top of the sliding-window RMS history testbench: clock, reset, stimulus, verdict.
// Depends on srh_pkg, the core and sliding_window_rms_history_checker.
module sliding_window_rms_history_core_test;
  import srh_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = CMD_SAMPLE;
  logic [1:0]  channel = '0;
  logic signed [15:0] sample = '0;
  logic [5:0]  age = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [1:0]  out_channel;
  logic [31:0] value;
  logic        valid_res;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int mismatches, pending, ticks_seen, reads_seen;
  int words_sent;
  int idle_cycles;
  int rx_wait;
  bit steady;
  int unsigned active_chans, active_hist;

  always #6 clk = ~clk;

  sliding_window_rms_history_core dut (.*);

  sliding_window_rms_history_checker checker_i (.*);

  // result side back-pressure
  always @(posedge clk) begin : rx_side
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (out_valid && out_ready) begin
      w = steady ? 0 : $urandom_range(0, 6);
      rx_wait   <= w;
      out_ready <= (w == 0);
    end else if (rx_wait > 0) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] op, logic [1:0] ch, logic signed [15:0] smp,
                           logic [5:0] ag);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    channel  <= ch;
    sample   <= smp;
    age      <= ag;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [2:0] nch, logic [8:0] wl, logic [6:0] hl);
    settle();
    write_reg(REG_NUM_CH, 16'(nch));
    write_reg(REG_WIN_LEN, 16'(wl));
    write_reg(REG_HIST_LEN, 16'(hl));
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 3))
        0: write_reg(3'(REG_GAIN0 + i), 16'd0);
        1: write_reg(3'(REG_GAIN0 + i), 16'hFFFF);
        2: write_reg(3'(REG_GAIN0 + i), 16'd256);
        default: write_reg(3'(REG_GAIN0 + i), 16'($urandom_range(0, 16'hFFFF)));
      endcase
    end
    active_chans = (nch > 4) ? 4 : nch;
    active_hist  = (hl == 0) ? 1 : ((hl > 64) ? 64 : hl);
  endtask

  task automatic random_words(int count);
    int pick;
    logic [1:0] ch;
    logic signed [15:0] smp;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      ch = (active_chans > 0 && $urandom_range(0, 9) != 0) ?
           2'($urandom_range(0, active_chans - 1)) : 2'($urandom_range(0, 3));
      smp = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                        : 16'($urandom_range(0, 400) - 200);
      if (pick < 68)
        send_word(CMD_SAMPLE, ch, smp, 6'($urandom_range(0, 63)));
      else if (pick < 80)
        send_word(CMD_TICK, ch, smp, 6'($urandom_range(0, 63)));
      else if (pick < 97)
        send_word(CMD_READ, ch, smp,
                  ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, active_hist - 1))
                                              : 6'($urandom_range(0, 63)));
      else
        send_word(CMD_UNUSED, ch, smp, 6'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    active_chans = 3;
    active_hist  = 64;
    steady = 1'b0;
    words_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults straight out of reset
    send_word(CMD_READ, 2'd0, 16'sd0, 6'd0);
    send_word(CMD_READ, 2'd2, 16'sd0, 6'd63);
    send_word(CMD_TICK, 2'd0, 16'sd0, 6'd0);
    send_word(CMD_SAMPLE, 2'd0, -16'sd32768, 6'd0);
    send_word(CMD_SAMPLE, 2'd0, 16'sd32767, 6'd0);
    send_word(CMD_SAMPLE, 2'd1, 16'sd32767, 6'd63);
    send_word(CMD_SAMPLE, 2'd1, 16'sd32767, 6'd0);
    send_word(CMD_SAMPLE, 2'd3, -16'sd1, 6'd0);
    send_word(CMD_UNUSED, 2'd1, 16'sd5, 6'd7);
    send_word(CMD_TICK, 2'd3, 16'sd0, 6'd0);
    send_word(CMD_READ, 2'd0, 16'sd0, 6'd0);
    send_word(CMD_READ, 2'd1, 16'sd0, 6'd1);
    send_word(CMD_READ, 2'd3, 16'sd0, 6'd0);
    send_word(CMD_READ, 2'd2, 16'sd0, 6'd0);

    configure(3'd4, 9'd1, 7'd1);
    send_word(CMD_SAMPLE, 2'd3, 16'sh5A5A, 6'd0);
    send_word(CMD_TICK, 2'd0, 16'sd0, 6'd0);
    send_word(CMD_READ, 2'd3, 16'sd0, 6'd0);
    send_word(CMD_READ, 2'd3, 16'sd0, 6'd1);
    configure(3'd0, 9'd8, 7'd4);
    send_word(CMD_SAMPLE, 2'd0, 16'sd100, 6'd0);
    send_word(CMD_TICK, 2'd0, 16'sd0, 6'd0);
    send_word(CMD_READ, 2'd0, 16'sd0, 6'd0);

    configure(3'd4, 9'd4, 7'd5);
    random_words(25);
    steady = 1'b1;
    configure(3'd7, 9'd511, 7'd127);
    random_words(20);
    steady = 1'b0;
    configure(3'd2, 9'd0, 7'd0);
    random_words(20);
    configure(3'd1, 9'd256, 7'd64);
    random_words(20);
    configure(3'd4, 9'd17, 7'd3);
    random_words(25);
    configure(3'd3, 9'd2, 7'd64);
    random_words(25);

    settle();
    $display("Sent %0d input words over nine register settings.", words_sent);
    $display("Checked %0d tick and %0d read result words.", ticks_seen, reads_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
